/* src/ghp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants for the gray-level histogram with peak tracking.
// ----------------------------------------------------------------------------
package ghp_pkg;

	// Bin store geometry
	localparam int BIN_COUNT      = 256;
	localparam int ADDR_BITS      = $clog2(BIN_COUNT);
	localparam int COUNT_BITS_DEF = 24;

	// Field widths of the words on the ports
	localparam int OP_BITS     = 2;
	localparam int PIXEL_BITS  = 8;
	localparam int COUNT_OUT_W = 24;
	localparam int HEIGHT_W    = 21;

	// Opcodes
	localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

	// Divide-by-ten: floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for any 32-bit n
	localparam int          DIVISOR       = 10;
	localparam logic [3:0]  REM_LAST      = 4'(DIVISOR - 1);
	localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int          RECIP10_SHIFT = 35;

	// Output ceilings
	localparam logic [31:0] COUNT_OUT_MAX  = 32'h00FF_FFFF;
	localparam logic [31:0] HEIGHT_OUT_MAX = 32'h001F_FFFF;

	typedef struct packed {
		logic [OP_BITS-1:0]    op;
		logic [PIXEL_BITS-1:0] pixel_value;
		logic [PIXEL_BITS-1:0] bin_index;
	} req_word_t;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] bin_count;
		logic [HEIGHT_W-1:0]    bar_height;
		logic [HEIGHT_W-1:0]    peak_height;
	} rsp_word_t;

	// Bin store control from the pipeline
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} store_ctl_t;

endpackage
`default_nettype wire

/* src/gray_histogram_with_peak.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gray_histogram_with_peak
// 256-bin gray-level histogram with saturating counts, bar height (count/10)
// and running peak bar height.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------------
//  req     | in  | req_valid/req_stall| op, pixel_value, bin_index
//  rsp     | out | rsp_valid/rsp_stall| bin_count, bar_height, peak_height
//
//  One word per cycle unless frozen: s0 reads the bin store, s1 updates/
//  writes back, s2 holds a read result for the divide-by-ten reciprocal
//  multiply, then the rsp register. Clear zeroes all per-entry valid flops
//  together. No clearing pass after reset. The whole pipe freezes only
//  while a response sits in rsp and rsp_stall is high.
// ----------------------------------------------------------------------------
module gray_histogram_with_peak #(
	parameter int COUNT_BITS = ghp_pkg::COUNT_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire ghp_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output ghp_pkg::rsp_word_t      rsp
);

	// peak/10 fits in COUNT_BITS-3 bits
	localparam int PDW = COUNT_BITS - 3;

	logic                          adv;
	logic                          acc;
	logic                          act;
	logic [ghp_pkg::ADDR_BITS-1:0] new_addr;
	ghp_pkg::store_ctl_t           ctl;
	logic [COUNT_BITS-1:0]         rd_data;
	logic [COUNT_BITS-1:0]         cur;
	logic [COUNT_BITS-1:0]         inc;

	// s1: item whose read data is arriving
	logic                          vld_s1;
	logic [ghp_pkg::OP_BITS-1:0]   op_s1;
	logic [ghp_pkg::ADDR_BITS-1:0] addr_s1;
	logic                          fz_s1;   // previous word was a clear
	logic                          fh_s1;   // previous word wrote this bin
	logic [COUNT_BITS-1:0]         fv_s1;

	// s2: read result waiting for the divide
	logic                          vld_s2;
	logic [COUNT_BITS-1:0]         cnt_s2;
	logic [PDW-1:0]                peak_div_s2;

	// peak tracking: count, and count split as div*10 + rem
	logic [COUNT_BITS-1:0]         peak_count_q;
	logic [PDW-1:0]                peak_div_q;
	logic [3:0]                    peak_rem_q;

	logic [31:0]                   cnt32;
	logic [63:0]                   prod;
	logic [31:0]                   bar32;
	logic [31:0]                   peak32;

	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;
	assign acc       = req_valid && adv;
	assign act       = vld_s1 && adv;

	assign new_addr = (req.op == ghp_pkg::OP_ADD) ? req.pixel_value : req.bin_index;

	// Current count of the s1 bin, with forwarding from the word just ahead
	assign cur = fz_s1 ? '0 : (fh_s1 ? fv_s1 : rd_data);
	assign inc = (&cur) ? cur : cur + 1'b1;

	assign ctl.rd_en   = acc;
	assign ctl.wr_en   = act && (op_s1 == ghp_pkg::OP_ADD);
	assign ctl.clr_all = act && (op_s1 == ghp_pkg::OP_CLEAR);

	ghp_bin_store #(
		.COUNT_BITS(COUNT_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (new_addr),
		.wr_addr (addr_s1),
		.wr_data (inc),
		.rd_data (rd_data)
	);

	// Control and peak state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			rsp_valid    <= 1'b0;
			peak_count_q <= '0;
			peak_div_q   <= '0;
			peak_rem_q   <= '0;
		end else begin
			if (adv) begin
				vld_s1    <= req_valid;
				vld_s2    <= vld_s1 && (op_s1 == ghp_pkg::OP_READ);
				rsp_valid <= vld_s2;
			end
			if (ctl.clr_all) begin
				peak_count_q <= '0;
				peak_div_q   <= '0;
				peak_rem_q   <= '0;
			end else if (ctl.wr_en && (inc > peak_count_q)) begin
				// counts grow by one, so the peak only ever steps by one
				peak_count_q <= inc;
				if (peak_rem_q == ghp_pkg::REM_LAST) begin
					peak_rem_q <= '0;
					peak_div_q <= peak_div_q + 1'b1;
				end else begin
					peak_rem_q <= peak_rem_q + 1'b1;
				end
			end
		end
	end

	// s1 payload and forwarding flags
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= req.op;
			addr_s1 <= new_addr;
			fz_s1   <= vld_s1 && (op_s1 == ghp_pkg::OP_CLEAR);
			fh_s1   <= vld_s1 && (op_s1 == ghp_pkg::OP_ADD) && (addr_s1 == new_addr);
			fv_s1   <= inc;
		end
	end

	// s2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s2      <= cur;
			peak_div_s2 <= peak_div_q;
		end
	end

	// Divide by ten through the reciprocal, then clamp to the field widths
	assign cnt32  = 32'(cnt_s2);
	assign prod   = 64'(cnt32) * 64'(ghp_pkg::RECIP10);
	assign bar32  = 32'(prod[63:ghp_pkg::RECIP10_SHIFT]);
	assign peak32 = 32'(peak_div_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.bin_count   <= (cnt32 > ghp_pkg::COUNT_OUT_MAX) ?
				ghp_pkg::COUNT_OUT_MAX[ghp_pkg::COUNT_OUT_W-1:0] :
				cnt32[ghp_pkg::COUNT_OUT_W-1:0];
			rsp.bar_height  <= (bar32 > ghp_pkg::HEIGHT_OUT_MAX) ?
				ghp_pkg::HEIGHT_OUT_MAX[ghp_pkg::HEIGHT_W-1:0] :
				bar32[ghp_pkg::HEIGHT_W-1:0];
			rsp.peak_height <= (peak32 > ghp_pkg::HEIGHT_OUT_MAX) ?
				ghp_pkg::HEIGHT_OUT_MAX[ghp_pkg::HEIGHT_W-1:0] :
				peak32[ghp_pkg::HEIGHT_W-1:0];
		end
	end

endmodule
`default_nettype wire

/* src/ghp_bin_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghp_bin_store
// 256-entry count memory, one read and one write port, registered read.
// Per-entry valid flops clear every entry at once; an invalid entry reads zero.
// ----------------------------------------------------------------------------
module ghp_bin_store #(
	parameter int COUNT_BITS = ghp_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ghp_pkg::store_ctl_t           ctl,
	input  wire logic [ghp_pkg::ADDR_BITS-1:0] rd_addr,
	input  wire logic [ghp_pkg::ADDR_BITS-1:0] wr_addr,
	input  wire logic [COUNT_BITS-1:0]         wr_data,
	output logic      [COUNT_BITS-1:0]         rd_data
);

	logic [COUNT_BITS-1:0]         mem [ghp_pkg::BIN_COUNT];
	logic [COUNT_BITS-1:0]         rdata_q;
	logic [ghp_pkg::BIN_COUNT-1:0] valid_q;
	logic                          rvld_q;

	// read-before-write on a same-address collision; the pipeline forwards
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

/* tb/sv/tb_gray_histogram_with_peak.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_histogram_with_peak
// Self-checking bench for the gray-level histogram. The request and response
// channels are driven with random idle and stall patterns. A bin tally kept
// in the bench predicts every read word, and the block's responses are
// compared with those predictions field by field, in order.
// ----------------------------------------------------------------------------
module tb_gray_histogram_with_peak;

	localparam logic [ghp_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
	localparam int LONG_HOLD   = 400;      // receiver hold-off, in cycles
	localparam int CYCLE_LIMIT = 300000;   // run aborts past this many cycles
	localparam int DRAIN_WAIT  = 12;       // margin after the last read response
	localparam int HOT_BINS    = 3;

	// ------------------------------------------------------------------------
	// Bin tally and ordered list of read words still owed by the block
	// ------------------------------------------------------------------------
	class histogram_checker;
		bit [31:0] bin_tally [ghp_pkg::BIN_COUNT];
		bit [31:0] peak_tally;
		bit [31:0] tally_ceiling;
		ghp_pkg::rsp_word_t owed_reads [$];
		int unsigned errors;

		function new();
			tally_ceiling = 32'((64'd1 << ghp_pkg::COUNT_BITS_DEF) - 64'd1);
			errors = 0;
			clear_tally();
		endfunction

		function void clear_tally();
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			peak_tally = '0;
		endfunction

		function bit [31:0] clamp(input bit [31:0] v, input bit [31:0] ceil_v);
			return (v > ceil_v) ? ceil_v : v;
		endfunction

		// Update the tally for one accepted request word.
		function void note_request(input ghp_pkg::req_word_t w);
			bit [31:0] c;
			bit [31:0] cnt_c;
			bit [31:0] bar_c;
			bit [31:0] peak_c;
			ghp_pkg::rsp_word_t e;
			case (w.op)
				ghp_pkg::OP_ADD: begin
					c = bin_tally[w.pixel_value];
					if (c < tally_ceiling)
						c = c + 1;
					bin_tally[w.pixel_value] = c;
					// peak follows the bin even when it sits at the ceiling
					if (c > peak_tally)
						peak_tally = c;
				end
				ghp_pkg::OP_READ: begin
					c = bin_tally[w.bin_index];
					cnt_c  = clamp(c, ghp_pkg::COUNT_OUT_MAX);
					bar_c  = clamp(c / ghp_pkg::DIVISOR, ghp_pkg::HEIGHT_OUT_MAX);
					peak_c = clamp(peak_tally / ghp_pkg::DIVISOR, ghp_pkg::HEIGHT_OUT_MAX);
					e.bin_count   = cnt_c[ghp_pkg::COUNT_OUT_W-1:0];
					e.bar_height  = bar_c[ghp_pkg::HEIGHT_W-1:0];
					e.peak_height = peak_c[ghp_pkg::HEIGHT_W-1:0];
					owed_reads.insert(owed_reads.size(), e);
				end
				ghp_pkg::OP_CLEAR: clear_tally();
				default: ;  // unused opcode: no effect
			endcase
		endfunction

		function void compare_field(input string name, input bit [31:0] exp_v,
				input bit [31:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			end
		endfunction

		// Compare one accepted response word with the oldest owed read.
		function void check_response(input ghp_pkg::rsp_word_t got);
			ghp_pkg::rsp_word_t e;
			if (owed_reads.size() == 0) begin
				errors++;
				$display("%0t: unexpected response: expected none, actual %h",
					$time, got);
				return;
			end
			e = owed_reads.pop_front();
			compare_field("bin_count",   32'(e.bin_count),   32'(got.bin_count));
			compare_field("bar_height",  32'(e.bar_height),  32'(got.bar_height));
			compare_field("peak_height", 32'(e.peak_height), 32'(got.peak_height));
		endfunction

		function int pending();
			return owed_reads.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, DUT
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	ghp_pkg::req_word_t req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	ghp_pkg::rsp_word_t rsp;

	always #4 clk = ~clk;

	gray_histogram_with_peak dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	histogram_checker hist_chk = new();

	// Idle pressure per phase, in percent of cycles
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;

	bit [ghp_pkg::PIXEL_BITS-1:0] hot_bin [HOT_BINS];

	// ------------------------------------------------------------------------
	// Monitor: both channels sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				hist_chk.note_request(req);
			if (rsp_valid && !rsp_stall)
				hist_chk.check_response(rsp);
		end
	end

	// Watchdog
	int unsigned cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reads outstanding", $time, hist_chk.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stall, plus one long hold-off on request
	// ------------------------------------------------------------------------
	event hold_kick;
	bit   long_hold = 1'b0;

	always begin
		@(hold_kick);
		long_hold = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n)
			rsp_stall <= long_hold || ($urandom_range(99) < rsp_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------
	// Random content for every field of a request word.
	function automatic ghp_pkg::req_word_t junk_word();
		bit [31:0] r;
		r = $urandom;
		return r[$bits(ghp_pkg::req_word_t)-1:0];
	endfunction

	function automatic logic [ghp_pkg::PIXEL_BITS-1:0] rand_bin();
		bit [31:0] r;
		r = $urandom;
		return r[ghp_pkg::PIXEL_BITS-1:0];
	endfunction

	// Offer one word; idle cycles first carry junk payload with valid low.
	task automatic send_word(input ghp_pkg::req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
			req       <= junk_word();
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic send_op(input logic [ghp_pkg::OP_BITS-1:0] op,
			input logic [ghp_pkg::PIXEL_BITS-1:0] pix,
			input logic [ghp_pkg::PIXEL_BITS-1:0] idx);
		ghp_pkg::req_word_t w;
		w.op          = op;
		w.pixel_value = pix;
		w.bin_index   = idx;
		send_word(w);
	endtask

	// Skewed toward a few hot bins so counts grow into visible bar heights.
	function automatic logic [ghp_pkg::PIXEL_BITS-1:0] pick_bin();
		if ($urandom_range(99) < 60)
			return hot_bin[$urandom_range(HOT_BINS - 1)];
		return rand_bin();
	endfunction

	// read_pm: share of reads in per mille; clears and unused ops stay rare.
	function automatic ghp_pkg::req_word_t random_word(input int unsigned read_pm);
		ghp_pkg::req_word_t w;
		int unsigned r;
		w = junk_word();  // unused fields get random content
		r = $urandom_range(999);
		if (r < 1000 - read_pm - 11) begin
			w.op = ghp_pkg::OP_ADD;
			w.pixel_value = pick_bin();
		end else if (r < 989) begin
			w.op = ghp_pkg::OP_READ;
			w.bin_index = pick_bin();
		end else if (r < 992)
			w.op = ghp_pkg::OP_CLEAR;
		else
			w.op = OP_UNUSED;
		return w;
	endfunction

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_words, input int unsigned read_pm);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (n_words)
			send_word(random_word(read_pm));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		foreach (hot_bin[i])
			hot_bin[i] = rand_bin();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty store, edge bins, unused fields, unused op, clear
		send_op(ghp_pkg::OP_READ,  8'h00, 8'h00);
		send_op(ghp_pkg::OP_READ,  8'hFF, 8'hFF);
		send_op(ghp_pkg::OP_ADD,   8'h00, 8'hFF);
		send_op(ghp_pkg::OP_ADD,   8'hFF, 8'h00);
		send_op(ghp_pkg::OP_ADD,   8'hFF, 8'hA5);
		send_op(ghp_pkg::OP_READ,  8'h5A, 8'hFF);
		send_op(ghp_pkg::OP_READ,  8'hFF, 8'h00);
		send_op(OP_UNUSED,         8'hFF, 8'hFF);
		send_op(ghp_pkg::OP_READ,  8'h00, 8'hFF);
		repeat (10)
			send_op(ghp_pkg::OP_ADD, 8'hAA, 8'h55);  // first bar height of one
		send_op(ghp_pkg::OP_READ,  8'h00, 8'hAA);
		send_op(ghp_pkg::OP_CLEAR, 8'hFF, 8'hFF);
		send_op(ghp_pkg::OP_READ,  8'h00, 8'hAA);
		send_op(ghp_pkg::OP_READ,  8'h00, 8'hFF);

		// Random phases
		run_phase(0,  0,  300, 230);
		run_phase(66, 0,  300, 230);
		run_phase(0,  66, 300, 230);
		run_phase(37, 37, 300, 230);

		// Long receiver hold-off while the sender keeps pushing, mostly reads,
		// so the pipe backs up and the request side stalls
		-> hold_kick;
		run_phase(0, 0, 60, 700);

		@(negedge clk);
		req_valid <= 1'b0;

		while (hist_chk.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (hist_chk.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* gray_histogram_with_peak.f */
src/ghp_pkg.sv
src/ghp_bin_store.sv
src/gray_histogram_with_peak.sv
tb/sv/tb_gray_histogram_with_peak.sv
